>>> rtl/lge_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Life generation engine package
// Grid dimensions, rule constants and request codes shared by the engine.
// ----------------------------------------------------------------------------
package lge_pkg;

    // Grid dimensions: one stored word per row, one bit per column.
    localparam int unsigned ROWS = 32;
    localparam int unsigned COLS = 64;

    // Address width of the row store.
    localparam int unsigned ROW_AW = $clog2(ROWS);

    // Field widths of the transfer payload.
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned DATA_W  = 64;

    // Neighbour count rule.
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    // Request codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

endpackage
`default_nettype wire

>>> rtl/lge_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  wire                                       aclk,
    input  wire                                       wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                           wr_data,
    input  wire                                       rd_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/lge_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Life cell lane
// Counts the eight neighbours of one cell and applies the birth and
// survival rule.
// ----------------------------------------------------------------------------
module lge_cell (
    input  wire [7:0] neighbours,
    input  wire       alive,
    output logic      next_alive
);

    logic [3:0] count;

    // Population count of the neighbourhood.
    always_comb begin
        count = 4'd0;
        for (int i = 0; i < 8; i++) begin
            count = count + {3'b000, neighbours[i]};
        end
    end

    // A live cell survives on two or three; a dead cell is born on three.
    always_comb begin
        if (alive) begin
            next_alive = (count >= lge_pkg::SURVIVE_LOW) && (count <= lge_pkg::SURVIVE_HIGH);
        end else begin
            next_alive = (count == lge_pkg::BIRTH_COUNT);
        end
    end

endmodule
`default_nettype wire

>>> rtl/lge_row_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Row update
// One cell lane per column computes the next generation of a row from the
// rows above, at and below it; the lanes are merged into one row word.
// ----------------------------------------------------------------------------
module lge_row_update (
    input  wire  [lge_pkg::COLS-1:0] above,
    input  wire  [lge_pkg::COLS-1:0] here,
    input  wire  [lge_pkg::COLS-1:0] below,
    output logic [lge_pkg::COLS-1:0] fresh
);

    // Rows padded with a dead column on each side, so column c sits at c+1.
    logic [lge_pkg::COLS+1:0] above_pad;
    logic [lge_pkg::COLS+1:0] here_pad;
    logic [lge_pkg::COLS+1:0] below_pad;
    logic [lge_pkg::COLS-1:0] lane_out;

    assign above_pad = {1'b0, above, 1'b0};
    assign here_pad  = {1'b0, here, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // One lane per column.
    for (genvar c = 0; c < lge_pkg::COLS; c++) begin : g_lane
        lge_cell u_cell (
            .neighbours ({above_pad[c], above_pad[c+1], above_pad[c+2],
                          here_pad[c],                  here_pad[c+2],
                          below_pad[c], below_pad[c+1], below_pad[c+2]}),
            .alive      (here[c]),
            .next_alive (lane_out[c])
        );
    end

    // Merge the lane results into the new row word.
    assign fresh = lane_out;

endmodule
`default_nettype wire

>>> rtl/life_generation_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Life generation engine
// Stores a grid of Life cells, one RAM word per row, and serves row writes,
// row reads and whole-grid generation steps.
// ----------------------------------------------------------------------------
// Request path: a write or unused kind passes through ST_FINISH, a read
// through ST_RDWAIT and ST_FINISH, an advance through the ST_SWEEP row sweep
// and ST_FINISH; ST_FINISH loads the output register, which holds the result.
// One item is in work at a time; the output register lets the next item
// enter while a result still waits, and ST_FINISH waits while it is occupied.
// Reset clears control state and the row valid bits, so every row reads dead.
// ----------------------------------------------------------------------------
module life_generation_engine (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [lge_pkg::KIND_W-1:0]   s_kind,
    input  wire  [lge_pkg::INDEX_W-1:0]  s_row_index,
    input  wire  [lge_pkg::DATA_W-1:0]   s_row_cells,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [lge_pkg::DATA_W-1:0]   m_row_cells_out
);

    localparam int unsigned STEP_W    = $clog2(lge_pkg::ROWS + 2);
    localparam int unsigned LAST_STEP = lge_pkg::ROWS + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [lge_pkg::COLS-1:0]     above_reg, above_next;
    logic [lge_pkg::COLS-1:0]     here_reg, here_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic [lge_pkg::ROWS-1:0]     valid_reg, valid_next;
    logic [lge_pkg::DATA_W-1:0]   result_reg, result_next;
    logic                         m_valid_reg, m_valid_next;
    logic [lge_pkg::DATA_W-1:0]   m_data_reg, m_data_next;

    logic                         ram_wr_en;
    logic [lge_pkg::ROW_AW-1:0]   ram_wr_addr;
    logic [lge_pkg::COLS-1:0]     ram_wr_data;
    logic                         ram_rd_en;
    logic [lge_pkg::ROW_AW-1:0]   ram_rd_addr;
    logic [lge_pkg::COLS-1:0]     ram_rd_data;

    logic                         in_range;
    logic [lge_pkg::ROW_AW-1:0]   in_addr;
    logic [lge_pkg::COLS-1:0]     below_row;
    logic [lge_pkg::COLS-1:0]     fresh_row;

    // Row store.
    lge_ram #(
        .WIDTH (lge_pkg::COLS),
        .DEPTH (lge_pkg::ROWS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next-generation lanes for the row in the middle of the window.
    lge_row_update u_row_update (
        .above (above_reg),
        .here  (here_reg),
        .below (below_row),
        .fresh (fresh_row)
    );

    // Request decode.
    assign in_range  = (32'(s_row_index) < lge_pkg::ROWS);
    assign in_addr   = lge_pkg::ROW_AW'(s_row_index);
    assign below_row = rd_ok_reg ? ram_rd_data : '0;

    // Sequencer and window control.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        above_next   = above_reg;
        here_next    = here_reg;
        rd_ok_next   = 1'b0;
        valid_next   = valid_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        lge_pkg::KIND_WRITE: begin
                            if (in_range) begin
                                ram_wr_en           = 1'b1;
                                ram_wr_addr         = in_addr;
                                ram_wr_data         = s_row_cells[lge_pkg::COLS-1:0];
                                valid_next[in_addr] = 1'b1;
                            end
                            result_next = '0;
                            state_next  = ST_FINISH;
                        end
                        lge_pkg::KIND_READ: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = in_addr;
                            rd_ok_next  = in_range && valid_reg[in_addr];
                            state_next  = ST_RDWAIT;
                        end
                        lge_pkg::KIND_ADVANCE: begin
                            step_next  = '0;
                            above_next = '0;
                            here_next  = '0;
                            state_next = ST_SWEEP;
                        end
                        default: begin
                            result_next = '0;
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                result_next = rd_ok_reg ? lge_pkg::DATA_W'(ram_rd_data) : '0;
                state_next  = ST_FINISH;
            end
            ST_SWEEP: begin
                // Fetch the row that becomes the lower edge of the window.
                if (32'(step_reg) < lge_pkg::ROWS) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = step_reg[lge_pkg::ROW_AW-1:0];
                    rd_ok_next  = valid_reg[step_reg[lge_pkg::ROW_AW-1:0]];
                end
                // Write back the new middle row once the window is full.
                if (step_reg >= STEP_W'(2)) begin
                    ram_wr_en               = 1'b1;
                    ram_wr_addr             = lge_pkg::ROW_AW'(step_reg - STEP_W'(2));
                    ram_wr_data             = fresh_row;
                    valid_next[ram_wr_addr] = 1'b1;
                end
                above_next = here_reg;
                here_next  = below_row;
                if (step_reg == STEP_W'(LAST_STEP)) begin
                    result_next = '0;
                    state_next  = ST_FINISH;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_ok_reg   <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ok_reg   <= rd_ok_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        above_reg  <= above_next;
        here_reg   <= here_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_row_cells_out = m_data_reg;

    // The sweep never writes the row it is fetching in the same cycle.
    a_sweep_ports_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("row store read and write collide during sweep");

    // The step counter stays within the sweep length.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (32'(step_reg) <= LAST_STEP))
        else $error("sweep step counter overran");

    // Every row has been rewritten once a sweep completes.
    a_sweep_fills_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && step_reg == STEP_W'(LAST_STEP)) |=> (&valid_reg))
        else $error("sweep left a row unwritten");

    // A finished result moves to the output register when it is free.
    a_finish_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_valid_reg || m_ready))
            |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Life generation engine testbench
// Drives row writes, row reads, generation steps and the unused request code
// into the engine, with random gaps and output stalls. A local copy of the
// grid predicts every result, and each result transfer is checked in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lge_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [lge_pkg::DATA_W-1:0] COL_MASK =
        {lge_pkg::DATA_W{1'b1}} >> (lge_pkg::DATA_W - lge_pkg::COLS);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [lge_pkg::KIND_W-1:0]   s_kind;
    logic [lge_pkg::INDEX_W-1:0]  s_row_index;
    logic [lge_pkg::DATA_W-1:0]   s_row_cells;
    logic                         m_valid;
    logic                         m_ready;
    logic [lge_pkg::DATA_W-1:0]   m_row_cells_out;

    // Local copy of the grid and the queue of row words still to come back.
    logic [lge_pkg::DATA_W-1:0] life_grid [lge_pkg::ROWS];
    logic [lge_pkg::DATA_W-1:0] expected_cells_q [$];

    // Idling controls for the two sides.
    bit tx_idle_en;
    bit rx_idle_en;

    int cycle_count;
    int fail_count;
    int checked_count;
    int write_count;
    int read_count;
    int advance_count;
    int unused_count;

    life_generation_engine u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_row_index     (s_row_index),
        .s_row_cells     (s_row_cells),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row_cells_out (m_row_cells_out)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles without finishing", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Next state of one row, taken from the old generation of its neighbors.
    function automatic logic [lge_pkg::DATA_W-1:0] evolve_row(
        input logic [lge_pkg::DATA_W-1:0] above,
        input logic [lge_pkg::DATA_W-1:0] here,
        input logic [lge_pkg::DATA_W-1:0] below);
        logic [lge_pkg::DATA_W-1:0] fresh;
        int                         n;
        fresh = '0;
        for (int c = 0; c < lge_pkg::COLS; c++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                if (c + d >= 0 && c + d < lge_pkg::COLS) begin
                    n += int'(above[c+d]) + int'(below[c+d]);
                    if (d != 0) n += int'(here[c+d]);
                end
            end
            if (here[c]) begin
                fresh[c] = (n >= int'(lge_pkg::SURVIVE_LOW)) &&
                           (n <= int'(lge_pkg::SURVIVE_HIGH));
            end else begin
                fresh[c] = (n == int'(lge_pkg::BIRTH_COUNT));
            end
        end
        return fresh & COL_MASK;
    endfunction

    // Applies one accepted request to the local grid and returns its answer.
    function automatic logic [lge_pkg::DATA_W-1:0] apply_request(
        input logic [lge_pkg::KIND_W-1:0]  kind,
        input logic [lge_pkg::INDEX_W-1:0] idx,
        input logic [lge_pkg::DATA_W-1:0]  cells);
        logic [lge_pkg::DATA_W-1:0] old_grid [lge_pkg::ROWS];
        logic [lge_pkg::DATA_W-1:0] answer;
        answer = '0;
        case (kind)
            lge_pkg::KIND_WRITE: begin
                if (idx < lge_pkg::ROWS) life_grid[idx] = cells & COL_MASK;
            end
            lge_pkg::KIND_READ: begin
                if (idx < lge_pkg::ROWS) answer = life_grid[idx] & COL_MASK;
            end
            lge_pkg::KIND_ADVANCE: begin
                old_grid = life_grid;
                for (int r = 0; r < lge_pkg::ROWS; r++) begin
                    life_grid[r] = evolve_row((r > 0) ? old_grid[r-1] : '0, old_grid[r],
                                              (r + 1 < lge_pkg::ROWS) ? old_grid[r+1] : '0);
                end
            end
            default: begin
            end
        endcase
        return answer;
    endfunction

    // Random row contents: sparse, even or dense.
    function automatic logic [lge_pkg::DATA_W-1:0] random_row();
        logic [lge_pkg::DATA_W-1:0] a;
        logic [lge_pkg::DATA_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0: return a & b & {$urandom, $urandom};
            1: return a;
            default: return a | b;
        endcase
    endfunction

    // Sends one request and records its expected answer on transfer.
    task automatic send_item(input logic [lge_pkg::KIND_W-1:0]  kind,
                             input logic [lge_pkg::INDEX_W-1:0] idx,
                             input logic [lge_pkg::DATA_W-1:0]  cells);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_row_index <= idx;
        s_row_cells <= cells;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_cells_q.push_back(apply_request(kind, idx, cells));
        case (kind)
            lge_pkg::KIND_WRITE:   write_count++;
            lge_pkg::KIND_READ:    read_count++;
            lge_pkg::KIND_ADVANCE: advance_count++;
            default:               unused_count++;
        endcase
    endtask

    // Holds off the sender until every outstanding answer has been returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_cells_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, then an in-order compare of each transfer.
    initial begin : result_checker
        int                         stall;
        logic [lge_pkg::DATA_W-1:0] want;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (expected_cells_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %h with nothing outstanding", m_row_cells_out);
            end else begin
                want = expected_cells_q.pop_front();
                checked_count++;
                if (m_row_cells_out !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("row_cells_out mismatch: expected %h, got %h",
                                 want, m_row_cells_out);
                end
            end
        end
    end

    // A grid fresh out of reset reads as all dead.
    task automatic test_reset_state();
        send_item(lge_pkg::KIND_READ, 5'd0, '0);
        send_item(lge_pkg::KIND_READ, 5'd31, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_READ, 5'd16, '0);
    endtask

    // Extreme rows, edge columns, every request code and the ignored fields.
    task automatic test_edges_and_kinds();
        send_item(lge_pkg::KIND_WRITE, 5'd0, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_WRITE, 5'd31, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_READ, 5'd0, '0);
        send_item(lge_pkg::KIND_READ, 5'd31, '0);
        // An advance ignores its index and cells.
        send_item(lge_pkg::KIND_ADVANCE, 5'd31, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_READ, 5'd0, '0);
        send_item(lge_pkg::KIND_READ, 5'd1, '0);
        send_item(lge_pkg::KIND_READ, 5'd31, '0);
        // The unused code must leave the grid alone and answer zero.
        send_item(KIND_UNUSED, 5'd0, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_READ, 5'd0, {lge_pkg::DATA_W{1'b1}});
        send_item(lge_pkg::KIND_WRITE, 5'd0, '0);
        send_item(lge_pkg::KIND_WRITE, 5'd31, '0);
        // Cells touching the first and last columns.
        send_item(lge_pkg::KIND_WRITE, 5'd15, 64'h8000_0000_0000_0001);
        send_item(lge_pkg::KIND_WRITE, 5'd16, 64'hC000_0000_0000_0003);
        send_item(lge_pkg::KIND_WRITE, 5'd14, 64'h5555_5555_5555_5555);
        send_item(lge_pkg::KIND_ADVANCE, 5'd0, '0);
        send_item(lge_pkg::KIND_READ, 5'd14, '0);
        send_item(lge_pkg::KIND_READ, 5'd15, '0);
        send_item(lge_pkg::KIND_READ, 5'd16, '0);
        send_item(lge_pkg::KIND_ADVANCE, 5'd10, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(lge_pkg::KIND_READ, 5'd15, '0);
        send_item(lge_pkg::KIND_WRITE, 5'd30, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(lge_pkg::KIND_READ, 5'd30, '0);
    endtask

    // Seeded grids run through several generations with reads in between.
    task automatic test_random_generations(input int item_budget);
        int                         sent;
        int                         steps;
        int                         pick;
        int                         base;
        int                         shift;
        logic [lge_pkg::DATA_W-1:0] glider [3];
        sent = 0;
        while (sent < item_budget) begin
            pick = $urandom_range(0, 3);
            tx_idle_en = pick[0];
            rx_idle_en = pick[1];
            // Sometimes start from an empty grid.
            if ($urandom_range(0, 3) == 0) begin
                for (int r = 0; r < lge_pkg::ROWS; r++) begin
                    send_item(lge_pkg::KIND_WRITE, lge_pkg::INDEX_W'(r), '0);
                    sent++;
                end
            end
            repeat ($urandom_range(4, 24)) begin
                send_item(lge_pkg::KIND_WRITE, lge_pkg::INDEX_W'($urandom_range(0, 31)),
                          random_row());
                sent++;
            end
            // A glider somewhere on the grid, edges included.
            if ($urandom_range(0, 1) == 1) begin
                base  = $urandom_range(0, lge_pkg::ROWS - 3);
                shift = $urandom_range(0, lge_pkg::COLS - 3);
                glider[0] = lge_pkg::DATA_W'(3'b010) << shift;
                glider[1] = lge_pkg::DATA_W'(3'b100) << shift;
                glider[2] = lge_pkg::DATA_W'(3'b111) << shift;
                for (int k = 0; k < 3; k++) begin
                    send_item(lge_pkg::KIND_WRITE, lge_pkg::INDEX_W'(base + k), glider[k]);
                    sent++;
                end
            end
            steps = $urandom_range(10, 40);
            repeat (steps) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    send_item(lge_pkg::KIND_ADVANCE, lge_pkg::INDEX_W'($urandom),
                              {$urandom, $urandom});
                    sent++;
                end else if (pick < 80) begin
                    send_item(lge_pkg::KIND_READ, lge_pkg::INDEX_W'($urandom),
                              {$urandom, $urandom});
                    sent++;
                end else if (pick < 93) begin
                    send_item(lge_pkg::KIND_WRITE, lge_pkg::INDEX_W'($urandom), random_row());
                    sent++;
                end else begin
                    send_item(KIND_UNUSED, lge_pkg::INDEX_W'($urandom), {$urandom, $urandom});
                end
            end
        end
    endtask

    // The sender stops until the engine has answered everything, then resumes.
    task automatic test_pause_and_resume();
        drain_results();
        tx_idle_en = 1'b0;
        send_item(lge_pkg::KIND_READ, lge_pkg::INDEX_W'($urandom), '0);
        send_item(lge_pkg::KIND_ADVANCE, '0, '0);
        send_item(lge_pkg::KIND_READ, lge_pkg::INDEX_W'($urandom), '0);
    endtask

    // Test sequence.
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_kind      = lge_pkg::KIND_WRITE;
        s_row_index = '0;
        s_row_cells = '0;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        fail_count    = 0;
        checked_count = 0;
        write_count   = 0;
        read_count    = 0;
        advance_count = 0;
        unused_count  = 0;
        for (int r = 0; r < lge_pkg::ROWS; r++) life_grid[r] = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_edges_and_kinds();
        test_random_generations(875);
        test_pause_and_resume();
        test_random_generations(875);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        fail_count += expected_cells_q.size();

        $display("covered %0d row writes, %0d row reads, %0d generation steps, %0d unused codes",
                 write_count, read_count, advance_count, unused_count);
        $display("%0d results compared, %0d failures, %0d cycles",
                 checked_count, fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lge_pkg.sv
rtl/lge_ram.sv
rtl/lge_cell.sv
rtl/lge_row_update.sv
rtl/life_generation_engine.sv
sim/tb.sv
